>>> sv/htom_pkg.sv
// Shared types and constants of the time-ordered heap merge unit.
// No dependencies; every other file of the unit but htom_ram refers to it by scoped names.
package htom_pkg;

    localparam int CHANNELS = 64;
    localparam int IDX_W    = $clog2(CHANNELS);
    localparam int CNT_W    = $clog2(CHANNELS + 1);
    localparam int TIME_W   = 64;
    localparam int MAXT_W   = 63;
    localparam int CHAN_W   = 6;
    localparam int TAG_W    = CHAN_W + 1;
    localparam int ENTRY_W  = TAG_W + TIME_W;

    // An exhausted channel sorts as the latest possible time.
    localparam logic [TIME_W-1:0] LATEST_TIME = {1'b0, {(TIME_W-1){1'b1}}};

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Tag layout: exhausted flag on top, channel number below it.
    typedef struct packed {
        logic              exh;
        logic [CHAN_W-1:0] chan;
        logic [TIME_W-1:0] evt_time;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BSTART,
        ST_ELEM_RD,
        ST_SEED,
        ST_SIFT_RD,
        ST_SIFT_CMP,
        ST_REP_RD,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic load;
        logic start_adv;
        logic start_build;
        logic seed;
        logic seed_adv;
        logic rd_kids;
        logic rd_top;
        logic cmp;
        logic next_elem;
        logic report;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic sift_done;
        logic base_zero;
        logic out_free;
    } t_sts;

endpackage

>>> sv/heap_time_ordered_merge_unit.sv
// Top level of the time-ordered heap merge unit: stream ports and beat packing.
// Depends on htom_pkg, htom_ctrl, htom_dp (and htom_ram below it).
//
// Channels are first loaded one beat each (opcode 0), and a load beat with
// tlast set builds the heap over all loaded entries and returns the earliest
// channel. Each advance beat (opcode 1) on a non-empty heap replaces the top
// entry's time and sifts it down, then returns the new earliest channel. The
// cost is set by the sift-down loop over the single heap memory: each level
// visited reads both children, then compares and writes one entry. An advance
// entry moves down at most log2 of the channel count levels. A build runs that
// sift loop once for every node from half the entry count down to the root.
// The input side takes one beat at a time; a finished result waits in an
// output register and the next beat is taken while it waits. The stop time is
// set by i_cfg_we.
module heap_time_ordered_merge_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [62:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // channel_id [5:0], event_time [69:6], zero [71:70]
    input  logic [1:0]  s_axis_tuser,   // opcode [0], exhausted [1]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // top_channel [5:0], top_time [69:6], zero [71:70]
    output logic [2:0]  m_axis_tuser    // done_res [0], new_timestamp [1], emit_value [2]
);

    htom_pkg::t_cmd              w_cmd;
    htom_pkg::t_sts              w_sts;
    logic [htom_pkg::CHAN_W-1:0] w_out_chan;
    logic [htom_pkg::TIME_W-1:0] w_out_time;
    logic                        w_out_done;
    logic                        w_out_stamp;
    logic                        w_out_emit;

    htom_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_opcode (s_axis_tuser[0]),
        .i_in_last   (s_axis_tlast),
        .i_sts       (w_sts),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (w_cmd)
    );

    htom_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_chan   (s_axis_tdata[5:0]),
        .i_in_time   (s_axis_tdata[69:6]),
        .i_in_exh    (s_axis_tuser[1]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (m_axis_tready),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .o_out_chan  (w_out_chan),
        .o_out_time  (w_out_time),
        .o_out_done  (w_out_done),
        .o_out_stamp (w_out_stamp),
        .o_out_emit  (w_out_emit)
    );

    assign m_axis_tdata = {2'b00, w_out_time, w_out_chan};
    assign m_axis_tuser = {w_out_emit, w_out_stamp, w_out_done};

endmodule

>>> sv/htom_ram.sv
// Generic memory with one write port and two registered read ports.
// No dependencies.
module htom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

>>> sv/htom_ctrl.sv
// Sequencer of the heap merge unit: loads, heap build, sift-down and report.
// Depends on htom_pkg; drives the datapath htom_dp through t_cmd / t_sts.
module htom_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_opcode,
    input  logic            i_in_last,
    input  htom_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output htom_pkg::t_cmd  o_cmd
);

    htom_pkg::t_state r_state;
    htom_pkg::t_state n_state;
    logic             r_is_adv;
    logic             n_is_adv;
    logic             w_accept;

    assign w_accept = i_in_valid && (r_state == htom_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= htom_pkg::ST_IDLE;
            r_is_adv <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_is_adv <= n_is_adv;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_is_adv = r_is_adv;
        case (r_state)
            htom_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_is_adv = (i_in_opcode == htom_pkg::OP_ADVANCE);
                    if (i_in_opcode == htom_pkg::OP_LOAD) begin
                        // A final load always leaves at least one entry to build over.
                        if (i_in_last) begin
                            n_state = htom_pkg::ST_BSTART;
                        end
                    end else if (!i_sts.empty) begin
                        n_state = htom_pkg::ST_ELEM_RD;
                    end
                end
            end
            htom_pkg::ST_BSTART:   n_state = htom_pkg::ST_ELEM_RD;
            htom_pkg::ST_ELEM_RD:  n_state = htom_pkg::ST_SEED;
            htom_pkg::ST_SEED:     n_state = htom_pkg::ST_SIFT_RD;
            htom_pkg::ST_SIFT_RD:  n_state = htom_pkg::ST_SIFT_CMP;
            htom_pkg::ST_SIFT_CMP: begin
                if (!i_sts.sift_done) begin
                    n_state = htom_pkg::ST_SIFT_RD;
                end else if (!r_is_adv && !i_sts.base_zero) begin
                    n_state = htom_pkg::ST_ELEM_RD;
                end else begin
                    n_state = htom_pkg::ST_REP_RD;
                end
            end
            htom_pkg::ST_REP_RD:   n_state = htom_pkg::ST_REPORT;
            htom_pkg::ST_REPORT: begin
                if (i_sts.out_free) begin
                    n_state = htom_pkg::ST_IDLE;
                end
            end
            default:               n_state = htom_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready        = (r_state == htom_pkg::ST_IDLE);
        o_cmd             = '0;
        o_cmd.load        = w_accept && (i_in_opcode == htom_pkg::OP_LOAD);
        o_cmd.start_adv   = w_accept && (i_in_opcode == htom_pkg::OP_ADVANCE)
                            && !i_sts.empty;
        o_cmd.start_build = (r_state == htom_pkg::ST_BSTART);
        o_cmd.seed        = (r_state == htom_pkg::ST_SEED);
        o_cmd.seed_adv    = r_is_adv;
        o_cmd.rd_kids     = (r_state == htom_pkg::ST_SIFT_RD);
        o_cmd.rd_top      = r_state inside {htom_pkg::ST_REP_RD, htom_pkg::ST_REPORT};
        o_cmd.cmp         = (r_state == htom_pkg::ST_SIFT_CMP);
        o_cmd.next_elem   = (r_state == htom_pkg::ST_SIFT_CMP) && i_sts.sift_done
                            && !r_is_adv && !i_sts.base_zero;
        o_cmd.report      = (r_state == htom_pkg::ST_REPORT) && i_sts.out_free;
    end

endmodule

>>> sv/htom_dp.sv
// Datapath of the heap merge unit: heap memory, sift registers, report logic
// and the output register. Depends on htom_pkg and htom_ram.
module htom_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  htom_pkg::t_cmd                i_cmd,
    input  logic [htom_pkg::CHAN_W-1:0]   i_in_chan,
    input  logic [htom_pkg::TIME_W-1:0]   i_in_time,
    input  logic                          i_in_exh,
    input  logic                          i_cfg_we,
    input  logic [htom_pkg::MAXT_W-1:0]   i_cfg_wdata,
    input  logic                          i_out_ready,
    output htom_pkg::t_sts                o_sts,
    output logic                          o_out_valid,
    output logic [htom_pkg::CHAN_W-1:0]   o_out_chan,
    output logic [htom_pkg::TIME_W-1:0]   o_out_time,
    output logic                          o_out_done,
    output logic                          o_out_stamp,
    output logic                          o_out_emit
);

    localparam int IW = htom_pkg::IDX_W;

    logic [htom_pkg::CNT_W-1:0]  r_count;
    logic [IW-1:0]               r_base;
    logic [IW-1:0]               r_i;
    htom_pkg::t_entry            r_v;
    logic [htom_pkg::TIME_W-1:0] r_new_time;
    logic                        r_new_exh;
    logic [htom_pkg::MAXT_W-1:0] r_stop_time;
    logic [htom_pkg::TIME_W-1:0] r_last_stamp;

    logic                        r_out_valid;
    logic [htom_pkg::CHAN_W-1:0] r_out_chan;
    logic [htom_pkg::TIME_W-1:0] r_out_time;
    logic                        r_out_done;
    logic                        r_out_stamp;
    logic                        r_out_emit;

    htom_pkg::t_entry            w_rd_a;
    htom_pkg::t_entry            w_rd_b;
    htom_pkg::t_entry            w_load_entry;
    htom_pkg::t_entry            w_wdata;
    logic                        w_we;
    logic [IW-1:0]               w_waddr;
    logic [IW-1:0]               w_raddr_a;
    logic                        w_full;

    logic [IW:0]                 w_l_idx;
    logic [IW+1:0]               w_r_idx;
    logic [IW+1:0]               w_count_x;
    logic                        w_l_ok;
    logic                        w_r_ok;
    logic                        w_l_lt_v;
    logic                        w_r_lt_v;
    logic                        w_r_lt_l;
    logic                        w_pick_l;
    logic                        w_pick_r;
    logic [IW-1:0]               w_best;

    logic [htom_pkg::TIME_W-1:0] w_rep_time;
    logic                        w_rep_nonneg;
    logic                        w_rep_done;
    logic                        w_rep_stamp;

    assign w_full    = (r_count == htom_pkg::CNT_W'(htom_pkg::CHANNELS));
    assign w_l_idx   = {r_i, 1'b1};
    assign w_r_idx   = {1'b0, r_i, 1'b0} + (IW+2)'(2);
    assign w_count_x = (IW+2)'(r_count);
    assign w_l_ok    = ({1'b0, w_l_idx} < w_count_x);
    assign w_r_ok    = (w_r_idx < w_count_x);

    // Strictly earlier only: on a tie the entry higher up, then the left child, stays.
    assign w_l_lt_v  = $signed(w_rd_a.evt_time) < $signed(r_v.evt_time);
    assign w_r_lt_v  = $signed(w_rd_b.evt_time) < $signed(r_v.evt_time);
    assign w_r_lt_l  = $signed(w_rd_b.evt_time) < $signed(w_rd_a.evt_time);
    assign w_pick_l  = w_l_ok && w_l_lt_v;
    assign w_pick_r  = w_r_ok && (w_pick_l ? w_r_lt_l : w_r_lt_v);
    assign w_best    = w_pick_r ? w_r_idx[IW-1:0] : w_l_idx[IW-1:0];

    always_comb begin
        w_load_entry.exh      = i_in_exh;
        w_load_entry.chan     = i_in_chan;
        w_load_entry.evt_time = i_in_exh ? htom_pkg::LATEST_TIME : i_in_time;
    end

    // The sifted entry is kept in r_v and written only where it comes to rest.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[IW-1:0];
        w_wdata = w_load_entry;
        if (i_cmd.cmp) begin
            w_we    = 1'b1;
            w_waddr = r_i;
            w_wdata = w_pick_r ? w_rd_b : (w_pick_l ? w_rd_a : r_v);
        end else if (i_cmd.load && !w_full) begin
            w_we    = 1'b1;
        end
    end

    always_comb begin
        if (i_cmd.rd_kids) begin
            w_raddr_a = w_l_idx[IW-1:0];
        end else if (i_cmd.rd_top) begin
            w_raddr_a = '0;
        end else begin
            w_raddr_a = r_i;
        end
    end

    htom_ram #(
        .WIDTH (htom_pkg::ENTRY_W),
        .DEPTH (htom_pkg::CHANNELS)
    ) u_heap (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_r_idx[IW-1:0]),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    assign w_rep_time   = w_rd_a.exh ? '0 : w_rd_a.evt_time;
    assign w_rep_nonneg = !w_rep_time[htom_pkg::TIME_W-1];
    assign w_rep_done   = w_rd_a.exh
                          || (w_rep_nonneg && (w_rep_time[htom_pkg::MAXT_W-1:0] > r_stop_time));
    assign w_rep_stamp  = !w_rep_done && w_rep_nonneg && (w_rep_time != r_last_stamp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_stop_time  <= '1;
            r_last_stamp <= '1;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load && !w_full) begin
                r_count <= r_count + htom_pkg::CNT_W'(1);
            end
            if (i_cfg_we) begin
                r_stop_time <= i_cfg_wdata;
            end
            if (i_cmd.report && w_rep_stamp) begin
                r_last_stamp <= w_rep_time;
            end
            if (i_cmd.report) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_adv) begin
            r_new_time <= i_in_exh ? htom_pkg::LATEST_TIME : i_in_time;
            r_new_exh  <= i_in_exh;
            r_i        <= '0;
        end
        if (i_cmd.start_build) begin
            r_base <= IW'(r_count >> 1);
            r_i    <= IW'(r_count >> 1);
        end
        if (i_cmd.seed) begin
            if (i_cmd.seed_adv) begin
                r_v.exh      <= r_new_exh;
                r_v.chan     <= w_rd_a.chan;
                r_v.evt_time <= r_new_time;
            end else begin
                r_v <= w_rd_a;
            end
        end
        if (i_cmd.cmp && (w_pick_l || w_pick_r)) begin
            r_i <= w_best;
        end
        if (i_cmd.next_elem) begin
            r_base <= r_base - IW'(1);
            r_i    <= r_base - IW'(1);
        end
        if (i_cmd.report) begin
            r_out_chan  <= w_rd_a.chan;
            r_out_time  <= w_rep_time;
            r_out_done  <= w_rep_done;
            r_out_stamp <= w_rep_stamp;
            r_out_emit  <= !w_rep_done && w_rep_nonneg;
        end
    end

    always_comb begin
        o_sts.empty     = (r_count == '0);
        o_sts.sift_done = !(w_pick_l || w_pick_r);
        o_sts.base_zero = (r_base == '0);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_chan  = r_out_chan;
    assign o_out_time  = r_out_time;
    assign o_out_done  = r_out_done;
    assign o_out_stamp = r_out_stamp;
    assign o_out_emit  = r_out_emit;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= htom_pkg::CNT_W'(htom_pkg::CHANNELS))
        else $error("heap entry count beyond capacity");

    a_sift_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cmp |-> (htom_pkg::CNT_W'(r_i) < r_count))
        else $error("sift step outside the filled heap");

    a_report_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.report |=> r_out_valid)
        else $error("report did not load the output register");

    a_stamp_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_stamp) |-> (r_out_emit && !r_out_done))
        else $error("new timestamp flagged on a result that emits nothing");

    a_stamp_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_stamp) |-> (r_last_stamp == r_out_time))
        else $error("last stamped time out of step with the stamped result");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> !i_cmd.cmp)
        else $error("load write collides with a sift write");
`endif

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for heap_time_ordered_merge_unit: stream stimulus, a behavioral
// heap predictor and a scoreboard of expected top reports. Depends on htom_pkg and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS = htom_pkg::CHANNELS;
    localparam int TIME_W   = htom_pkg::TIME_W;
    localparam int MAXT_W   = htom_pkg::MAXT_W;
    localparam int CHAN_W   = htom_pkg::CHAN_W;
    localparam int TAG_W    = htom_pkg::TAG_W;

    localparam int CLK_HALF      = 6;
    localparam int SETTLE_CYCLES = 40;
    localparam int LIMIT_CYCLES  = 10_000_000;
    localparam int RANDOM_ITEMS  = 1630;
    localparam int MAX_REPORTS   = 30;

    localparam logic [MAXT_W-1:0] LIMIT_ALL = '1;
    localparam logic [TIME_W-1:0] TIME_MIN  = {1'b1, {(TIME_W-1){1'b0}}};
    localparam logic [TIME_W-1:0] TIME_MAX  = {1'b0, {(TIME_W-1){1'b1}}};

    typedef struct packed {
        logic              op;
        logic [CHAN_W-1:0] chan;
        logic [TIME_W-1:0] tm;
        logic              exh;
        logic              last;
    } t_beat;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [TIME_W-1:0] tm;
        logic              done;
        logic              stamp;
        logic              emit;
    } t_top;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [62:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // channel_id [5:0], event_time [69:6], zero [71:70]
    logic [1:0]  s_axis_tuser;   // opcode [0], exhausted [1]
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // top_channel [5:0], top_time [69:6], zero [71:70]
    logic [2:0]  m_axis_tuser;   // done_res [0], new_timestamp [1], emit_value [2]

    heap_time_ordered_merge_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Predicted heap contents and merge state.
    logic [TIME_W-1:0] heap_times [CHANNELS];
    logic [TAG_W-1:0]  heap_tags  [CHANNELS];
    int unsigned       held_count;
    logic [TIME_W-1:0] stamped_time;
    logic [MAXT_W-1:0] time_limit;

    t_top top_reports_q[$];

    int  n_errors;
    int  n_beats;
    int  n_checked;
    int  n_builds;
    int  n_limit_writes;
    bit  calm;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic bit earlier(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic void sift_from(int unsigned idx);
        int unsigned kid;
        int unsigned best;
        logic [TIME_W-1:0] t;
        logic [TAG_W-1:0]  g;
        while (1'b1) begin
            best = idx;
            kid  = 2 * idx + 1;
            // The left child is tried first; only a strictly earlier time moves the pick.
            if (kid < held_count && earlier(heap_times[kid], heap_times[best]))
                best = kid;
            if (kid + 1 < held_count && earlier(heap_times[kid + 1], heap_times[best]))
                best = kid + 1;
            if (best == idx)
                break;
            t = heap_times[idx];
            g = heap_tags[idx];
            heap_times[idx]  = heap_times[best];
            heap_tags[idx]   = heap_tags[best];
            heap_times[best] = t;
            heap_tags[best]  = g;
            idx = best;
        end
    endfunction

    function automatic t_top top_report();
        t_top r;
        logic nonneg;
        r.chan = heap_tags[0][CHAN_W-1:0];
        r.tm   = heap_tags[0][TAG_W-1] ? '0 : heap_times[0];
        nonneg = !r.tm[TIME_W-1];
        r.done  = heap_tags[0][TAG_W-1] || (nonneg && r.tm[MAXT_W-1:0] > time_limit);
        r.stamp = !r.done && nonneg && r.tm != stamped_time;
        r.emit  = !r.done && nonneg;
        if (r.stamp)
            stamped_time = r.tm;
        return r;
    endfunction

    function automatic void predict_beat(t_beat b);
        logic [TIME_W-1:0] t;
        t = b.exh ? htom_pkg::LATEST_TIME : b.tm;
        if (b.op == htom_pkg::OP_LOAD) begin
            // A load into a full heap is dropped, but its tlast still rebuilds.
            if (held_count < CHANNELS) begin
                heap_times[held_count] = t;
                heap_tags[held_count]  = {b.exh, b.chan};
                held_count++;
            end
            if (b.last && held_count != 0) begin
                for (int i = held_count / 2; i >= 0; i--)
                    sift_from(i);
                n_builds++;
                top_reports_q.push_back(top_report());
            end
        end else if (held_count != 0) begin
            heap_times[0] = t;
            heap_tags[0]  = {b.exh, heap_tags[0][CHAN_W-1:0]};
            sift_from(0);
            top_reports_q.push_back(top_report());
        end
    endfunction

    function automatic t_beat mk_beat(logic op, logic [CHAN_W-1:0] chan,
                                      logic [TIME_W-1:0] tm, logic exh, logic last);
        t_beat b;
        b.op   = op;
        b.chan = chan;
        b.tm   = tm;
        b.exh  = exh;
        b.last = last;
        return b;
    endfunction

    // Mostly back to back, sometimes a short gap, rarely a long pause; none when calm.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(string name, logic [TIME_W-1:0] want,
                                        logic [TIME_W-1:0] got);
        if (want !== got) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endfunction

    task automatic send_beat(input t_beat b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, b.tm, b.chan};
        s_axis_tuser  <= {b.exh, b.op};
        s_axis_tlast  <= b.last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_beat(b);
        n_beats++;
    endtask

    // Holds the sender off until every predicted report has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (top_reports_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [MAXT_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        time_limit  = value;
        n_limit_writes++;
    endtask

    task automatic test_empty_advance();
        send_beat(mk_beat(htom_pkg::OP_ADVANCE, 6'd17, 64'd42, 1'b0, 1'b1));
        send_beat(mk_beat(htom_pkg::OP_ADVANCE, 6'd3, 64'd0, 1'b1, 1'b0));
        drain_results();
    endtask

    // Entries held without a build: the advance still sifts over them.
    task automatic test_advance_unbuilt();
        send_beat(mk_beat(htom_pkg::OP_LOAD, 6'd63, TIME_MIN, 1'b0, 1'b0));
        send_beat(mk_beat(htom_pkg::OP_LOAD, 6'd0, TIME_MAX, 1'b0, 1'b0));
        send_beat(mk_beat(htom_pkg::OP_LOAD, 6'd5, '1, 1'b0, 1'b0));
        send_beat(mk_beat(htom_pkg::OP_ADVANCE, 6'd42, 64'd0, 1'b0, 1'b0));
        drain_results();
    endtask

    task automatic test_build_and_ties();
        send_beat(mk_beat(htom_pkg::OP_LOAD, 6'd1, 64'd7, 1'b1, 1'b1));
        send_beat(mk_beat(htom_pkg::OP_LOAD, 6'd10, 64'd100, 1'b0, 1'b0));
        send_beat(mk_beat(htom_pkg::OP_LOAD, 6'd11, 64'd100, 1'b0, 1'b0));
        send_beat(mk_beat(htom_pkg::OP_LOAD, 6'd12, 64'd100, 1'b0, 1'b1));
        send_beat(mk_beat(htom_pkg::OP_ADVANCE, 6'd0, 64'd100, 1'b0, 1'b0));
        send_beat(mk_beat(htom_pkg::OP_ADVANCE, 6'd0, 64'd100, 1'b0, 1'b1));
        drain_results();
    endtask

    task automatic test_time_limit();
        write_limit('0);
        send_beat(mk_beat(htom_pkg::OP_ADVANCE, 6'd9, 64'd0, 1'b0, 1'b0));
        send_beat(mk_beat(htom_pkg::OP_ADVANCE, 6'd9, 64'd1, 1'b0, 1'b0));
        write_limit(LIMIT_ALL);
        send_beat(mk_beat(htom_pkg::OP_ADVANCE, 6'd9, TIME_MAX, 1'b0, 1'b0));
        drain_results();
    endtask

    task automatic test_exhausted_top();
        send_beat(mk_beat(htom_pkg::OP_ADVANCE, 6'd2, 64'd300, 1'b1, 1'b0));
        send_beat(mk_beat(htom_pkg::OP_ADVANCE, 6'd2, 64'd300, 1'b1, 1'b1));
        send_beat(mk_beat(htom_pkg::OP_ADVANCE, 6'd2, 64'd5, 1'b0, 1'b0));
        drain_results();
    endtask

    // Mostly well-formed merging: most advances move the top channel a little forward
    // in time. Loads keep growing the heap until it is full; the rest is noise.
    task automatic test_random_merge();
        int counted;
        int phase_len;
        int sel;
        logic [MAXT_W-1:0] lim;
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] neg;
        t_beat b;
        counted = 0;
        for (int ph = 0; counted < RANDOM_ITEMS; ph++) begin
            case (ph % 6)
                0: lim = LIMIT_ALL;
                1: lim = '0;
                3: lim = MAXT_W'({$urandom, $urandom});
                5: lim = LIMIT_ALL;
                default: lim = stamped_time[MAXT_W-1:0] + $urandom_range(0, 400);
            endcase
            write_limit(lim);
            calm = (ph % 4 == 3);
            phase_len = $urandom_range(60, 160);
            for (int k = 0; k < phase_len && counted < RANDOM_ITEMS; k++) begin
                sel  = $urandom_range(0, 99);
                base = heap_tags[0][TAG_W-1] ? stamped_time : heap_times[0];
                b.op   = htom_pkg::OP_ADVANCE;
                b.chan = CHAN_W'($urandom_range(0, 63));
                b.exh  = 1'b0;
                b.last = 1'($urandom_range(0, 1));
                b.tm   = base + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60));
                if (sel < 6) begin
                    b.exh = 1'b1;
                end else if (sel >= 72 && sel < 80) begin
                    neg  = TIME_W'($urandom_range(1, 80));
                    b.tm = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0 - neg;
                    b.exh = ($urandom_range(0, 4) == 0);
                end else if (sel >= 80) begin
                    b.op   = htom_pkg::OP_LOAD;
                    b.exh  = ($urandom_range(0, 9) == 0);
                    b.last = ($urandom_range(0, 3) == 0);
                    b.tm   = base + $urandom_range(0, 200);
                    if (sel >= 97)
                        b.tm = {$urandom, $urandom};
                end
                counted++;
                send_beat(b);
                if ($urandom_range(0, 199) == 0)
                    drain_results();
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        s_axis_tlast  <= 1'b0;
        held_count     = 0;
        stamped_time   = '1;
        time_limit     = LIMIT_ALL;
        n_errors       = 0;
        n_beats        = 0;
        n_checked      = 0;
        n_builds       = 0;
        n_limit_writes = 0;
        calm           = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_advance();
        test_advance_unbuilt();
        test_build_and_ties();
        test_time_limit();
        test_exhausted_top();
        test_random_merge();
        drain_results();

        $display("covered %0d beats, %0d heap builds, %0d stop-time writes;",
                 n_beats, n_builds, n_limit_writes);
        $display("checked %0d top reports, ending with %0d entries held", n_checked, held_count);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Receiver back-pressure follows the same gap profile as the sender.
    initial begin
        int stall;
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_top want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (top_reports_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: unexpected beat, expected none actual %h %h",
                             $time, m_axis_tdata, m_axis_tuser);
            end else begin
                want = top_reports_q.pop_front();
                check_field("top_channel", TIME_W'(want.chan), TIME_W'(m_axis_tdata[5:0]));
                check_field("top_time", want.tm, m_axis_tdata[69:6]);
                check_field("done_res", TIME_W'(want.done), TIME_W'(m_axis_tuser[0]));
                check_field("new_timestamp", TIME_W'(want.stamp), TIME_W'(m_axis_tuser[1]));
                check_field("emit_value", TIME_W'(want.emit), TIME_W'(m_axis_tuser[2]));
                n_checked++;
            end
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
        $display("tb: failure");
        $finish;
    end

endmodule
